### src/dpsm_pkg.sv
// Shared types and controlword and statusword constants for the drive power state machine.
package dpsm_pkg;

    // Statusword remote bit, always set.
    localparam logic [15:0] SW_RMT_BIT     = 16'h0200;

    // Controlword masks and match values.
    localparam logic [15:0] CW_MASK_SHUT   = 16'h0087;
    localparam logic [15:0] CW_VAL_SHUT    = 16'h0006;
    localparam logic [15:0] CW_MASK_CMD    = 16'h008F;
    localparam logic [15:0] CW_VAL_SWON    = 16'h0007;
    localparam logic [15:0] CW_VAL_ENOP    = 16'h000F;
    localparam logic [15:0] CW_MASK_DISV   = 16'h0082;
    localparam logic [15:0] CW_MASK_QSTOP  = 16'h0004;
    localparam logic [15:0] CW_FLT_RST     = 16'h0080;

    // Statusword state bits.
    localparam logic [15:0] SW_DISABLED    = 16'h0040;
    localparam logic [15:0] SW_READY       = 16'h0021;
    localparam logic [15:0] SW_SWITCHED    = 16'h0033;
    localparam logic [15:0] SW_OPENABLED   = 16'h0037;
    localparam logic [15:0] SW_QSTOP       = 16'h0017;
    localparam logic [15:0] SW_FLT_STATE   = 16'h0008;

    // Request kinds.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FAULT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] controlword;
        logic [15:0] fault_code;
        logic        fault_cleared;
    } dpsm_in_t;

    typedef struct packed {
        logic [15:0] status_word;
        logic [2:0]  state_code;
        logic [15:0] last_error;
        logic        power_on_pulse;
        logic        power_off_pulse;
        logic        drive_on_pulse;
        logic        drive_off_pulse;
        logic        quick_stop_pulse;
        logic        fault_react_pulse;
    } dpsm_out_t;

endpackage

### src/drive_power_state_machine.sv
// Drive power state machine: input register, transition logic, result register.
// A request waits in the input register until the result register is free or being emptied.
// Throughput: one request per cycle while the result side keeps taking results.
// The state and error latch update as a request moves into the result register.
// Reset: state switch-on-disabled, error latch zero, both stages empty.
module drive_power_state_machine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dpsm_pkg::dpsm_in_t  req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dpsm_pkg::dpsm_out_t rsp_data
);
    import dpsm_pkg::*;

    typedef enum logic [2:0] {
        ST_DISABLED  = 3'd0,
        ST_READY     = 3'd1,
        ST_SWITCHED  = 3'd2,
        ST_OPENABLED = 3'd3,
        ST_QSTOP     = 3'd4,
        ST_FAULT     = 3'd5
    } drive_state_t;

    drive_state_t state_reg, state_next;
    logic [15:0]  error_reg, error_next;
    logic         in_vld_reg;
    dpsm_in_t     in_reg;
    logic         out_vld_reg;
    dpsm_out_t    out_reg, out_next;
    logic         advance;
    logic [15:0]  cw;
    logic         p_on, p_off, d_on, d_off, qs, fr;

    function automatic logic [15:0] status_of(drive_state_t s);
        logic [15:0] sw;
        sw = SW_RMT_BIT;
        unique case (s)
            ST_DISABLED:  sw = sw | SW_DISABLED;
            ST_READY:     sw = sw | SW_READY;
            ST_SWITCHED:  sw = sw | SW_SWITCHED;
            ST_OPENABLED: sw = sw | SW_OPENABLED;
            ST_QSTOP:     sw = sw | SW_QSTOP;
            ST_FAULT:     sw = sw | SW_FLT_STATE;
            default:      sw = SW_RMT_BIT;
        endcase
        return sw;
    endfunction

    // Move the held request on when the result register is free or being emptied.
    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign req_ready = !in_vld_reg || advance;
    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_reg;
    assign cw        = in_reg.controlword;

    always_comb
    begin
        state_next = state_reg;
        error_next = error_reg;
        p_on  = 1'b0;
        p_off = 1'b0;
        d_on  = 1'b0;
        d_off = 1'b0;
        qs    = 1'b0;
        fr    = 1'b0;
        if (in_reg.cmd == CMD_FAULT)
        begin
            error_next = in_reg.fault_code;
            state_next = ST_FAULT;
            fr         = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_DISABLED:
                begin
                    if ((cw & CW_MASK_SHUT) == CW_VAL_SHUT)
                        state_next = ST_READY;
                end
                ST_READY:
                begin
                    priority if ((cw & CW_MASK_CMD) == CW_VAL_SWON)
                    begin
                        state_next = ST_SWITCHED;
                        p_on       = 1'b1;
                    end
                    else if ((cw & CW_MASK_DISV) == 16'h0000)
                    begin
                        state_next = ST_DISABLED;
                        p_off      = 1'b1;
                    end
                    else
                    begin
                        state_next = state_reg;
                    end
                end
                ST_SWITCHED:
                begin
                    priority if ((cw & CW_MASK_CMD) == CW_VAL_ENOP)
                    begin
                        state_next = ST_OPENABLED;
                        d_on       = 1'b1;
                    end
                    else if ((cw & CW_MASK_SHUT) == CW_VAL_SHUT)
                    begin
                        state_next = ST_READY;
                        p_off      = 1'b1;
                    end
                    else if ((cw & CW_MASK_DISV) == 16'h0000)
                    begin
                        state_next = ST_DISABLED;
                        p_off      = 1'b1;
                    end
                    else
                    begin
                        state_next = state_reg;
                    end
                end
                ST_OPENABLED:
                begin
                    priority if ((cw & CW_MASK_CMD) == CW_VAL_SWON)
                    begin
                        state_next = ST_SWITCHED;
                        d_off      = 1'b1;
                    end
                    else if ((cw & CW_MASK_QSTOP) == 16'h0000)
                    begin
                        state_next = ST_QSTOP;
                        qs         = 1'b1;
                    end
                    else if ((cw & CW_MASK_DISV) == 16'h0000)
                    begin
                        state_next = ST_DISABLED;
                        d_off      = 1'b1;
                        p_off      = 1'b1;
                    end
                    else
                    begin
                        state_next = state_reg;
                    end
                end
                ST_QSTOP:
                begin
                    // among controlwords, only enable operation leaves quick stop
                    if ((cw & CW_MASK_CMD) == CW_VAL_ENOP)
                    begin
                        state_next = ST_OPENABLED;
                        d_on       = 1'b1;
                    end
                end
                ST_FAULT:
                begin
                    // hold fault until a fault reset is asked and the hardware reports it clear
                    if (((cw & CW_FLT_RST) != 16'h0000) && in_reg.fault_cleared)
                        state_next = ST_DISABLED;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        out_next.status_word       = status_of(state_next);
        out_next.state_code        = state_next;
        out_next.last_error        = error_next;
        out_next.power_on_pulse    = p_on;
        out_next.power_off_pulse   = p_off;
        out_next.drive_on_pulse    = d_on;
        out_next.drive_off_pulse   = d_off;
        out_next.quick_stop_pulse  = qs;
        out_next.fault_react_pulse = fr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_DISABLED;
            error_reg   <= 16'h0000;
            in_vld_reg  <= 1'b0;
            in_reg      <= '0;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                in_reg <= req_data;
            end
            if (req_ready)
            begin
                in_vld_reg <= req_valid;
            end
            if (advance)
            begin
                state_reg   <= state_next;
                error_reg   <= error_next;
                out_reg     <= out_next;
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    a_fault_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.cmd == CMD_FAULT) |=>
            (rsp_data.state_code == ST_FAULT) && rsp_data.fault_react_pulse)
        else $error("fault event did not land in the fault state");

    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.state_code == state_reg)
                      && (rsp_data.last_error == error_reg))
        else $error("shown result disagrees with the held state");

    a_power_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.power_on_pulse && rsp_data.power_off_pulse)
                      && !(rsp_data.drive_on_pulse && rsp_data.drive_off_pulse))
        else $error("opposing action pulses raised together");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (rsp_valid && !rsp_ready))
        else $error("request side stalled without a result stall");

endmodule
